@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the grid box occupancy block.
// Depends on nothing; the including module provides clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define GBQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("gbq assertion failed");

// The expression must never be true at a rising clock edge outside reset.
`define GBQ_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("gbq forbidden condition seen");

`endif

@@ rtl/gbq_pkg.sv @@
// Package of the grid box occupancy block: sizes, codes, payload structs
// and the controller state type. Depends on nothing.
package gbq_pkg;

  localparam int DEF_MAX_X       = 16;
  localparam int DEF_MAX_Y       = 16;
  localparam int DEF_MAX_Z       = 16;
  localparam int DEF_MAX_OBJECTS = 64;

  localparam int CRD_W     = 5;
  localparam int CNT_W     = 7;
  localparam int CELL_W    = 7;
  localparam int ID_W      = 6;
  localparam int MARK_W    = 16;
  localparam int FUNC_W    = 2;
  localparam int STAT_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int OCC_BIT   = 6;

  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FIN   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OFF  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_Z = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [CRD_W-1:0]  low_x;
    logic [CRD_W-1:0]  low_y;
    logic [CRD_W-1:0]  low_z;
    logic [CRD_W-1:0]  high_x;
    logic [CRD_W-1:0]  high_y;
    logic [CRD_W-1:0]  high_z;
    logic [MARK_W-1:0] query_mark;
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]   object_id;
    logic              found;
    logic [STAT_W-1:0] status;
    logic              last;
  } res_t;

  typedef enum logic [8:0] {
    ST_CLR  = 9'b000000001,
    ST_IDLE = 9'b000000010,
    ST_PUT  = 9'b000000100,
    ST_FRD  = 9'b000001000,
    ST_FWR  = 9'b000010000,
    ST_QRD  = 9'b000100000,
    ST_QCK  = 9'b001000000,
    ST_QMK  = 9'b010000000,
    ST_QEND = 9'b100000000
  } state_e;

endpackage

@@ rtl/gbq_cell_ram.sv @@
// Single-port cell memory of the grid box occupancy block, registered read.
// Depends on nothing.
module gbq_cell_ram #(
  parameter int AW = 12,
  parameter int DW = 7
) (
  input  logic          clk_i,
  input  logic [AW-1:0] addr_i,
  input  logic          we_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

@@ rtl/grid_box_occupancy_query.sv @@
// Top level of the grid box occupancy block: controller, seen-mark memory.
// Depends on gbq_pkg, gbq_cell_ram and assert_macros.svh.

// After reset the block clears its cell memory, one entry per cycle, all
// 2**(clog2(MAX_X)+clog2(MAX_Y)+clog2(MAX_Z)) entries (4096 at the default
// sizes), and keeps busy_o high meanwhile. A put writes each cell of the
// clipped box; a finalize reads each cell of the grid in use and rewrites
// each unoccupied one; a query reads each cell visited and checks the seen
// mark of each occupied one. The cell memory has a single port and a
// registered read. Results appear for one cycle on result_o with
// result_valid_o; the receiver cannot stall them.
`include "assert_macros.svh"

module grid_box_occupancy_query #(
  parameter int MAX_X       = gbq_pkg::DEF_MAX_X,
  parameter int MAX_Y       = gbq_pkg::DEF_MAX_Y,
  parameter int MAX_Z       = gbq_pkg::DEF_MAX_Z,
  parameter int MAX_OBJECTS = gbq_pkg::DEF_MAX_OBJECTS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  gbq_pkg::cmd_t                      cmd_i,
  output logic                               result_valid_o,
  output gbq_pkg::res_t                      result_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [gbq_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [gbq_pkg::CRD_W-1:0]          cfg_data_i
);

  localparam int XW = (MAX_X > 1) ? $clog2(MAX_X) : 1;
  localparam int YW = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
  localparam int ZW = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
  localparam int AW = XW + YW + ZW;
  localparam int OW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int CW = gbq_pkg::CNT_W;
  localparam int GW = gbq_pkg::CRD_W;

  function automatic logic [GW-1:0] sat_size(logic [GW-1:0] v, int lim);
    logic [GW-1:0] r;
    if (v == '0) begin
      r = GW'(1);
    end else if (int'(v) > lim) begin
      r = GW'(lim);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [CW-1:0] clip(logic [GW-1:0] v, logic [GW-1:0] lim);
    return (v > lim) ? CW'(lim) : CW'(v);
  endfunction

  gbq_pkg::state_e state_q, state_d;
  logic [GW-1:0] grid_x_q, grid_y_q, grid_z_q;
  logic [CW-1:0] put_cnt_q, put_cnt_d;
  logic [CW-1:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic [CW-1:0] lo_y_q, lo_y_d, lo_z_q, lo_z_d;
  logic [CW-1:0] hi_x_q, hi_x_d, hi_y_q, hi_y_d, hi_z_q, hi_z_d;
  logic [gbq_pkg::MARK_W-1:0] mark_q, mark_d;
  logic seen_q, seen_d;
  logic [gbq_pkg::ID_W-1:0] dist_q, dist_d;
  logic [CW-1:0] nfound_q, nfound_d;
  logic pend_vld_q, pend_vld_d;
  logic [gbq_pkg::ID_W-1:0] pend_id_q, pend_id_d;
  logic [gbq_pkg::ID_W-1:0] id_q, id_d;
  logic [AW-1:0] clr_q;
  gbq_pkg::res_t res_q, res_d;
  logic res_vld_q, res_vld_d;
  logic [MAX_OBJECTS-1:0] seen_vld_q;

  logic [AW-1:0] mem_addr;
  logic mem_we;
  logic [gbq_pkg::CELL_W-1:0] mem_wdata, mem_rdata;

  logic [gbq_pkg::MARK_W-1:0] seen_mem [MAX_OBJECTS];
  logic [gbq_pkg::MARK_W-1:0] seen_rd_q, seen_val;
  logic [OW-1:0] seen_raddr;
  logic seen_we;

  logic [CW-1:0] hx_c, hy_c, hz_c, x_inc, y_inc, z_inc, z_skip;
  logic [CW-1:0] lx_c, ly_c, lz_c;

  assign busy_o         = (state_q != gbq_pkg::ST_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

  assign hx_c   = clip(cmd_i.high_x, grid_x_q);
  assign hy_c   = clip(cmd_i.high_y, grid_y_q);
  assign hz_c   = clip(cmd_i.high_z, grid_z_q);
  assign lx_c   = CW'(cmd_i.low_x);
  assign ly_c   = CW'(cmd_i.low_y);
  assign lz_c   = CW'(cmd_i.low_z);
  assign x_inc  = x_q + CW'(1);
  assign y_inc  = y_q + CW'(1);
  assign z_inc  = z_q + CW'(1);
  assign z_skip = z_q + CW'(mem_rdata[gbq_pkg::ID_W-1:0]);

  assign mem_addr  = (state_q == gbq_pkg::ST_CLR) ? clr_q
                   : {x_q[XW-1:0], y_q[YW-1:0], z_q[ZW-1:0]};
  assign seen_raddr = mem_rdata[OW-1:0];
  assign seen_val   = seen_vld_q[id_q[OW-1:0]] ? seen_rd_q : '0;

  gbq_cell_ram #(
    .AW(AW),
    .DW(gbq_pkg::CELL_W)
  ) u_cell_ram (
    .clk_i  (clk_i),
    .addr_i (mem_addr),
    .we_i   (mem_we),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (seen_we) begin
      seen_mem[id_q[OW-1:0]] <= mark_q;
    end
    seen_rd_q <= seen_mem[seen_raddr];
  end

  always_comb begin
    state_d   = state_q;
    put_cnt_d = put_cnt_q;
    x_d = x_q; y_d = y_q; z_d = z_q;
    lo_y_d = lo_y_q; lo_z_d = lo_z_q;
    hi_x_d = hi_x_q; hi_y_d = hi_y_q; hi_z_d = hi_z_q;
    mark_d     = mark_q;
    seen_d     = seen_q;
    dist_d     = dist_q;
    nfound_d   = nfound_q;
    pend_vld_d = pend_vld_q;
    pend_id_d  = pend_id_q;
    id_d       = id_q;
    res_d      = res_q;
    res_vld_d  = 1'b0;
    mem_we     = 1'b0;
    mem_wdata  = '0;
    seen_we    = 1'b0;

    unique case (state_q) inside
      gbq_pkg::ST_CLR: begin
        mem_we = 1'b1;
        if (clr_q == '1) begin
          state_d = gbq_pkg::ST_IDLE;
        end
      end
      gbq_pkg::ST_IDLE: begin
        if (start_i) begin
          lo_y_d = ly_c; lo_z_d = lz_c;
          hi_x_d = hx_c; hi_y_d = hy_c; hi_z_d = hz_c;
          x_d = lx_c; y_d = ly_c; z_d = lz_c;
          mark_d     = cmd_i.query_mark;
          nfound_d   = '0;
          pend_vld_d = 1'b0;
          res_d      = '{object_id: '0, found: 1'b0, status: gbq_pkg::STAT_OK, last: 1'b1};
          res_vld_d  = 1'b1;
          case (cmd_i.func)
            gbq_pkg::FUNC_PUT: begin
              if (cmd_i.low_x >= grid_x_q || cmd_i.low_y >= grid_y_q ||
                  cmd_i.low_z >= grid_z_q) begin
                res_d.status = gbq_pkg::STAT_OFF;
              end else if (put_cnt_q >= CW'(MAX_OBJECTS)) begin
                res_d.status = gbq_pkg::STAT_FULL;
              end else if (lx_c < hx_c && ly_c < hy_c && lz_c < hz_c) begin
                res_vld_d = 1'b0;
                state_d   = gbq_pkg::ST_PUT;
              end else begin
                res_d.object_id = put_cnt_q[gbq_pkg::ID_W-1:0];
                res_d.found     = 1'b1;
                put_cnt_d       = put_cnt_q + CW'(1);
              end
            end
            gbq_pkg::FUNC_FIN: begin
              res_vld_d = 1'b0;
              x_d       = '0;
              y_d       = '0;
              z_d       = CW'(grid_z_q) - CW'(1);
              seen_d    = 1'b0;
              dist_d    = '0;
              state_d   = gbq_pkg::ST_FRD;
            end
            gbq_pkg::FUNC_QUERY: begin
              if (lx_c < hx_c && ly_c < hy_c && lz_c < hz_c) begin
                res_vld_d = 1'b0;
                state_d   = gbq_pkg::ST_QRD;
              end
            end
            default: begin
              res_vld_d = 1'b1;
            end
          endcase
        end
      end
      gbq_pkg::ST_PUT: begin
        mem_we    = 1'b1;
        mem_wdata = {1'b1, put_cnt_q[gbq_pkg::ID_W-1:0]};
        if (z_inc < hi_z_q) begin
          z_d = z_inc;
        end else begin
          z_d = lo_z_q;
          if (y_inc < hi_y_q) begin
            y_d = y_inc;
          end else begin
            y_d = lo_y_q;
            if (x_inc < hi_x_q) begin
              x_d = x_inc;
            end else begin
              res_d = '{object_id: put_cnt_q[gbq_pkg::ID_W-1:0], found: 1'b1,
                        status: gbq_pkg::STAT_OK, last: 1'b1};
              res_vld_d = 1'b1;
              put_cnt_d = put_cnt_q + CW'(1);
              state_d   = gbq_pkg::ST_IDLE;
            end
          end
        end
      end
      gbq_pkg::ST_FRD: begin
        state_d = gbq_pkg::ST_FWR;
      end
      gbq_pkg::ST_FWR: begin
        state_d = gbq_pkg::ST_FRD;
        if (mem_rdata[gbq_pkg::OCC_BIT]) begin
          seen_d = 1'b1;
          dist_d = '0;
        end else if (seen_q) begin
          dist_d    = dist_q + gbq_pkg::ID_W'(1);
          mem_we    = 1'b1;
          mem_wdata = {1'b0, dist_q + gbq_pkg::ID_W'(1)};
        end else begin
          mem_we = 1'b1;
        end
        if (z_q == '0) begin
          seen_d = 1'b0;
          dist_d = '0;
          z_d    = CW'(grid_z_q) - CW'(1);
          if (y_inc < CW'(grid_y_q)) begin
            y_d = y_inc;
          end else begin
            y_d = '0;
            if (x_inc < CW'(grid_x_q)) begin
              x_d = x_inc;
            end else begin
              res_d = '{object_id: '0, found: 1'b0, status: gbq_pkg::STAT_OK,
                        last: 1'b1};
              res_vld_d = 1'b1;
              state_d   = gbq_pkg::ST_IDLE;
            end
          end
        end else begin
          z_d = z_q - CW'(1);
        end
      end
      gbq_pkg::ST_QRD: begin
        state_d = gbq_pkg::ST_QCK;
      end
      gbq_pkg::ST_QCK, gbq_pkg::ST_QMK: begin
        logic next_col;
        next_col = 1'b0;
        if (state_q == gbq_pkg::ST_QCK) begin
          id_d = mem_rdata[gbq_pkg::ID_W-1:0];
          if (mem_rdata[gbq_pkg::OCC_BIT]) begin
            state_d = gbq_pkg::ST_QMK;
          end else if (mem_rdata[gbq_pkg::ID_W-1:0] != '0) begin
            z_d      = z_skip;
            next_col = (z_skip >= hi_z_q);
            state_d  = gbq_pkg::ST_QRD;
          end else begin
            next_col = 1'b1;
          end
        end else begin
          if (seen_val != mark_q && nfound_q < CW'(MAX_OBJECTS)) begin
            seen_we    = 1'b1;
            nfound_d   = nfound_q + CW'(1);
            pend_vld_d = 1'b1;
            pend_id_d  = id_q;
            if (pend_vld_q) begin
              res_d = '{object_id: pend_id_q, found: 1'b1, status: gbq_pkg::STAT_OK,
                        last: 1'b0};
              res_vld_d = 1'b1;
            end
          end
          z_d      = z_inc;
          next_col = (z_inc >= hi_z_q);
          state_d  = gbq_pkg::ST_QRD;
        end
        if (next_col) begin
          z_d     = lo_z_q;
          state_d = gbq_pkg::ST_QRD;
          if (y_inc < hi_y_q) begin
            y_d = y_inc;
          end else begin
            y_d = lo_y_q;
            if (x_inc < hi_x_q) begin
              x_d = x_inc;
            end else begin
              state_d = gbq_pkg::ST_QEND;
            end
          end
        end
      end
      gbq_pkg::ST_QEND: begin
        res_d = '{object_id: pend_vld_q ? pend_id_q : '0, found: pend_vld_q,
                  status: gbq_pkg::STAT_OK, last: 1'b1};
        res_vld_d  = 1'b1;
        pend_vld_d = 1'b0;
        state_d    = gbq_pkg::ST_IDLE;
      end
      default: begin
        state_d = gbq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= gbq_pkg::ST_CLR;
      clr_q      <= '0;
      grid_x_q   <= sat_size(GW'(16), MAX_X);
      grid_y_q   <= sat_size(GW'(16), MAX_Y);
      grid_z_q   <= sat_size(GW'(16), MAX_Z);
      put_cnt_q  <= '0;
      res_vld_q  <= 1'b0;
      pend_vld_q <= 1'b0;
      seen_vld_q <= '0;
    end else begin
      state_q    <= state_d;
      put_cnt_q  <= put_cnt_d;
      res_vld_q  <= res_vld_d;
      pend_vld_q <= pend_vld_d;
      if (state_q == gbq_pkg::ST_CLR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (seen_we) begin
        seen_vld_q[id_q[OW-1:0]] <= 1'b1;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          gbq_pkg::CFG_GRID_X: grid_x_q <= sat_size(cfg_data_i, MAX_X);
          gbq_pkg::CFG_GRID_Y: grid_y_q <= sat_size(cfg_data_i, MAX_Y);
          gbq_pkg::CFG_GRID_Z: grid_z_q <= sat_size(cfg_data_i, MAX_Z);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d;
    lo_y_q <= lo_y_d; lo_z_q <= lo_z_d;
    hi_x_q <= hi_x_d; hi_y_q <= hi_y_d; hi_z_q <= hi_z_d;
    mark_q    <= mark_d;
    seen_q    <= seen_d;
    dist_q    <= dist_d;
    nfound_q  <= nfound_d;
    pend_id_q <= pend_id_d;
    id_q      <= id_d;
    res_q     <= res_d;
  end

  `GBQ_ASSERT(a_last_ends_work, result_valid_o && result_o.last |-> !busy_o)
  `GBQ_ASSERT(a_more_follow, result_valid_o && !result_o.last |-> busy_o)
  `GBQ_ASSERT(a_accept_acts, start_i && !busy_o |=> busy_o || result_valid_o)
  `GBQ_NEVER(a_count_bound, put_cnt_q > CW'(MAX_OBJECTS))

endmodule

@@ sim/grid_box_occupancy_query_tb.sv @@
// Self-checking testbench for grid_box_occupancy_query: a directed table, then
// random puts, finalizes and queries over several grid sizes, checked against a
// behavioral predictor. Depends on gbq_pkg and the RTL of the block.
module grid_box_occupancy_query_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MX = gbq_pkg::DEF_MAX_X;
  localparam int MY = gbq_pkg::DEF_MAX_Y;
  localparam int MZ = gbq_pkg::DEF_MAX_Z;
  localparam int MOBJ = gbq_pkg::DEF_MAX_OBJECTS;
  localparam int STALL_LIMIT = 100000;
  localparam logic [gbq_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef logic [gbq_pkg::CRD_W-1:0]  crd_t;
  typedef logic [gbq_pkg::MARK_W-1:0] mark_t;
  typedef logic [gbq_pkg::CELL_W-1:0] cell_t;

  typedef struct {
    gbq_pkg::cmd_t cmd;
    bit            typed;
    gbq_pkg::res_t res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  gbq_pkg::cmd_t cmd_i = '0;
  logic result_valid_o;
  gbq_pkg::res_t result_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [gbq_pkg::CFG_IDX_W-1:0] cfg_index_i = gbq_pkg::CFG_GRID_X;
  crd_t cfg_data_i = '0;

  cell_t cells [MX*MY*MZ];
  mark_t marks [MOBJ];
  int serials;
  int gx, gy, gz;
  gbq_pkg::res_t expected_q [$];
  int errors, n_items, n_results, n_puts, n_queries;
  int quiet;
  bit no_gaps;

  grid_box_occupancy_query u_top (
    .clk_i, .rst_ni, .start_i, .busy_o, .cmd_i, .result_valid_o, .result_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int cell_idx(int x, int y, int z);
    return (x * MY + y) * MZ + z;
  endfunction

  function automatic int saturate(crd_t v, int m);
    if (v == '0) return 1;
    if (int'(v) > m) return m;
    return int'(v);
  endfunction

  function automatic gbq_pkg::res_t mk(int id, bit f, logic [gbq_pkg::STAT_W-1:0] st);
    gbq_pkg::res_t r;
    r.object_id = id[gbq_pkg::ID_W-1:0];
    r.found = f;
    r.status = st;
    r.last = 1'b0;
    return r;
  endfunction

  // Updates the occupancy state and returns the results one command causes.
  function automatic void occupancy_step(gbq_pkg::cmd_t c, ref gbq_pkg::res_t out [$]);
    int hx, hy, hz, z, lo;
    cell_t v;
    bit seen;
    int run_len;
    out.delete();
    hx = (c.high_x > gx) ? gx : int'(c.high_x);
    hy = (c.high_y > gy) ? gy : int'(c.high_y);
    hz = (c.high_z > gz) ? gz : int'(c.high_z);
    case (c.func)
      gbq_pkg::FUNC_PUT: begin
        if (c.low_x >= gx || c.low_y >= gy || c.low_z >= gz) begin
          out.insert(out.size(), mk(0, 1'b0, gbq_pkg::STAT_OFF));
        end else if (serials >= MOBJ) begin
          out.insert(out.size(), mk(0, 1'b0, gbq_pkg::STAT_FULL));
        end else begin
          v = {1'b1, serials[gbq_pkg::ID_W-1:0]};
          for (int x = c.low_x; x < hx; x++)
            for (int y = c.low_y; y < hy; y++)
              for (int zz = c.low_z; zz < hz; zz++) cells[cell_idx(x, y, zz)] = v;
          out.insert(out.size(), mk(serials, 1'b1, gbq_pkg::STAT_OK));
          serials++;
        end
      end
      gbq_pkg::FUNC_FIN: begin
        for (int x = 0; x < gx; x++)
          for (int y = 0; y < gy; y++) begin
            seen = 0;
            run_len = 0;
            for (int zz = gz - 1; zz >= 0; zz--) begin
              if (cells[cell_idx(x, y, zz)][gbq_pkg::OCC_BIT]) begin
                seen = 1;
                run_len = 0;
              end else if (seen) begin
                run_len++;
                cells[cell_idx(x, y, zz)] = {1'b0, run_len[gbq_pkg::ID_W-1:0]};
              end else begin
                cells[cell_idx(x, y, zz)] = '0;
              end
            end
          end
        out.insert(out.size(), mk(0, 1'b0, gbq_pkg::STAT_OK));
      end
      gbq_pkg::FUNC_QUERY: begin
        for (int x = c.low_x; x < hx; x++)
          for (int y = c.low_y; y < hy; y++) begin
            z = c.low_z;
            while (z < hz) begin
              v = cells[cell_idx(x, y, z)];
              lo = int'(v[gbq_pkg::ID_W-1:0]);
              if (v[gbq_pkg::OCC_BIT]) begin
                if (marks[lo] != c.query_mark && out.size() < MOBJ) begin
                  marks[lo] = c.query_mark;
                  out.insert(out.size(), mk(lo, 1'b1, gbq_pkg::STAT_OK));
                end
                z++;
              end else if (lo > 0) begin
                z += lo;
              end else begin
                break;
              end
            end
          end
        if (out.size() == 0) out.insert(out.size(), mk(0, 1'b0, gbq_pkg::STAT_OK));
      end
      default: out.insert(out.size(), mk(0, 1'b0, gbq_pkg::STAT_OK));
    endcase
    out[out.size()-1].last = 1'b1;
  endfunction

  task automatic issue(gbq_pkg::cmd_t c, bit typed, gbq_pkg::res_t typed_res);
    gbq_pkg::res_t out [$];
    if (!no_gaps && $urandom_range(0, 99) < 25) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy_o);
    occupancy_step(c, out);
    if (typed) expected_q.insert(expected_q.size(), typed_res);
    else foreach (out[i]) expected_q.insert(expected_q.size(), out[i]);
    n_items++;
    if (c.func == gbq_pkg::FUNC_PUT) n_puts++;
    if (c.func == gbq_pkg::FUNC_QUERY) n_queries++;
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_grid(logic [gbq_pkg::CFG_IDX_W-1:0] idx, crd_t val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      gbq_pkg::CFG_GRID_X: gx = saturate(val, MX);
      gbq_pkg::CFG_GRID_Y: gy = saturate(val, MY);
      default: gz = saturate(val, MZ);
    endcase
    @(posedge clk_i);
  endtask

  function automatic crd_t pick_low(int g);
    if ($urandom_range(0, 9) == 0) return crd_t'($urandom_range(0, 31));
    return crd_t'($urandom_range(0, g - 1));
  endfunction

  function automatic crd_t pick_high(crd_t lo);
    int h;
    if ($urandom_range(0, 9) == 0) return crd_t'($urandom_range(0, 31));
    h = int'(lo) + int'($urandom_range(0, 6));
    return crd_t'((h > 31) ? 31 : h);
  endfunction

  function automatic gbq_pkg::cmd_t random_cmd();
    gbq_pkg::cmd_t c;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) c.func = gbq_pkg::FUNC_PUT;
    else if (roll < 35) c.func = gbq_pkg::FUNC_FIN;
    else if (roll < 95) c.func = gbq_pkg::FUNC_QUERY;
    else c.func = FUNC_UNUSED;
    c.low_x = pick_low(gx);
    c.low_y = pick_low(gy);
    c.low_z = pick_low(gz);
    c.high_x = pick_high(c.low_x);
    c.high_y = pick_high(c.low_y);
    c.high_z = pick_high(c.low_z);
    c.query_mark = ($urandom_range(0, 3) == 0) ? mark_t'($urandom_range(0, 65535))
                                              : mark_t'($urandom_range(1, 3));
    return c;
  endfunction

  function automatic gbq_pkg::cmd_t box(logic [gbq_pkg::FUNC_W-1:0] f, int lx, int ly,
                                        int lz, int hx, int hy, int hz, int m);
    gbq_pkg::cmd_t c;
    c.func = f;
    c.low_x = crd_t'(lx); c.low_y = crd_t'(ly); c.low_z = crd_t'(lz);
    c.high_x = crd_t'(hx); c.high_y = crd_t'(hy); c.high_z = crd_t'(hz);
    c.query_mark = mark_t'(m);
    return c;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      n_results++;
      if (expected_q.size() == 0) begin
        $error("unexpected result: object_id %0d found %0b status %0d last %0b",
               result_o.object_id, result_o.found, result_o.status, result_o.last);
        errors++;
      end else begin
        gbq_pkg::res_t e;
        e = expected_q.pop_front();
        if (result_o.object_id !== e.object_id) begin
          $error("object_id expected %0d actual %0d", e.object_id, result_o.object_id);
          errors++;
        end
        if (result_o.found !== e.found) begin
          $error("found expected %0b actual %0b", e.found, result_o.found);
          errors++;
        end
        if (result_o.status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, result_o.status);
          errors++;
        end
        if (result_o.last !== e.last) begin
          $error("last expected %0b actual %0b", e.last, result_o.last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o || (cfg_valid_i && cfg_ready_o)) quiet = 0;
    else quiet++;
    if (quiet >= STALL_LIMIT) begin
      $display("grid_box_occupancy_query regression: fail");
      $finish;
    end
  end

  initial begin
    row_t rows [$];
    gbq_pkg::res_t none, r_last;
    int sizes [5][3];
    sizes = '{'{16, 16, 16}, '{1, 1, 1}, '{0, 31, 2}, '{5, 9, 7}, '{31, 16, 31}};
    foreach (cells[i]) cells[i] = '0;
    foreach (marks[i]) marks[i] = '0;
    serials = 0;
    gx = MX; gy = MY; gz = MZ;
    errors = 0; n_items = 0; n_results = 0; n_puts = 0; n_queries = 0; quiet = 0;
    no_gaps = 0;
    none = mk(0, 1'b0, gbq_pkg::STAT_OK);
    none.last = 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_grid(gbq_pkg::CFG_GRID_X, crd_t'(16));
    write_grid(gbq_pkg::CFG_GRID_Y, crd_t'(16));
    write_grid(gbq_pkg::CFG_GRID_Z, crd_t'(16));

    r_last = mk(0, 1'b0, gbq_pkg::STAT_OFF);
    r_last.last = 1'b1;
    rows.insert(rows.size(), '{box(gbq_pkg::FUNC_QUERY, 0, 0, 0, 31, 31, 31, 1), 1, none});
    rows.insert(rows.size(), '{box(gbq_pkg::FUNC_PUT, 16, 0, 0, 17, 1, 1, 0), 1, r_last});
    rows.insert(rows.size(), '{box(gbq_pkg::FUNC_PUT, 0, 31, 0, 1, 31, 1, 0), 1, r_last});
    rows.insert(rows.size(), '{box(gbq_pkg::FUNC_PUT, 0, 0, 31, 1, 1, 31, 0), 1, r_last});
    r_last = mk(0, 1'b1, gbq_pkg::STAT_OK);
    r_last.last = 1'b1;
    rows.insert(rows.size(), '{box(gbq_pkg::FUNC_PUT, 0, 0, 0, 31, 31, 31, 0), 1, r_last});
    rows.insert(rows.size(), '{box(gbq_pkg::FUNC_PUT, 3, 3, 3, 6, 5, 9, 0), 0, none});
    rows.insert(rows.size(), '{box(gbq_pkg::FUNC_PUT, 4, 4, 4, 2, 2, 2, 0), 0, none});
    rows.insert(rows.size(), '{box(gbq_pkg::FUNC_PUT, 15, 15, 15, 16, 16, 16, 0), 0, none});
    rows.insert(rows.size(), '{box(gbq_pkg::FUNC_QUERY, 0, 0, 0, 16, 16, 16, 0), 1, none});
    rows.insert(rows.size(),
                '{box(gbq_pkg::FUNC_QUERY, 2, 2, 2, 8, 8, 12, 16'hFFFF), 0, none});
    rows.insert(rows.size(),
                '{box(gbq_pkg::FUNC_QUERY, 2, 2, 2, 8, 8, 12, 16'hFFFF), 0, none});
    rows.insert(rows.size(), '{box(gbq_pkg::FUNC_PUT, 7, 7, 10, 8, 8, 12, 0), 0, none});
    rows.insert(rows.size(), '{box(gbq_pkg::FUNC_PUT, 8, 8, 0, 9, 9, 16, 0), 0, none});
    rows.insert(rows.size(),
                '{box(gbq_pkg::FUNC_FIN, 31, 31, 31, 0, 0, 0, 16'hFFFF), 1, none});
    rows.insert(rows.size(),
                '{box(gbq_pkg::FUNC_QUERY, 0, 0, 0, 16, 16, 16, 16'h8000), 0, none});
    rows.insert(rows.size(), '{box(FUNC_UNUSED, 31, 31, 31, 31, 31, 31, 16'hFFFF), 1, none});
    rows.insert(rows.size(),
                '{box(gbq_pkg::FUNC_QUERY, 7, 7, 0, 9, 9, 16, 16'h0001), 0, none});
    foreach (rows[i]) issue(rows[i].cmd, rows[i].typed, rows[i].res);
    drain();

    foreach (sizes[p]) begin
      write_grid(gbq_pkg::CFG_GRID_X, crd_t'(sizes[p][0]));
      write_grid(gbq_pkg::CFG_GRID_Y, crd_t'(sizes[p][1]));
      write_grid(gbq_pkg::CFG_GRID_Z, crd_t'(sizes[p][2]));
      no_gaps = (p == 1);
      repeat (70) issue(random_cmd(), 0, none);
      drain();
    end

    $display("covered %0d commands (%0d puts, %0d queries), %0d results checked,",
             n_items, n_puts, n_queries, n_results);
    $display("five grid sizes including the saturated and degenerate ones");
    if (errors == 0) begin
      $display("grid_box_occupancy_query regression: pass");
    end else begin
      $display("grid_box_occupancy_query regression: fail");
    end
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/gbq_pkg.sv
rtl/gbq_cell_ram.sv
rtl/grid_box_occupancy_query.sv
sim/grid_box_occupancy_query_tb.sv
